// ----- rtl/awas_pkg.sv -----
// Package for the ADC window average scaler: widths, register indexes, reset values.
// No dependencies; used by every module in rtl/ except awas_ram.
package awas_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int NUM_CH      = 6;
    localparam int DEF_WINDOW  = 128;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_VREF_CAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_COLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_HOT  = 2'd2;

    localparam logic [11:0] RST_VREF_CAL = 12'd1500;
    localparam logic [11:0] RST_CAL_COLD = 12'd940;
    localparam logic [11:0] RST_CAL_HOT  = 12'd1200;

    // One scan as the front part hands it to the back part.
    typedef struct packed {
        logic [SAMPLE_W-1:0] avg_vout;
        logic [SAMPLE_W-1:0] avg_vin;
        logic [SAMPLE_W-1:0] avg_isense;
        logic [SAMPLE_W-1:0] avg_temp;
        logic [SAMPLE_W-1:0] avg_vref;
        logic [SAMPLE_W-1:0] ir;
    } t_avg;

    typedef struct packed {
        logic [15:0] vin_mv;
        logic [15:0] vout_mv;
        logic [13:0] current_ma;
        logic [11:0] ir_level;
        logic [11:0] temp_tenths;
        logic        temp_valid;
    } t_res;

endpackage

// ----- rtl/awas_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module awas_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/awas_front.sv -----
// Front part: window history, running sums and averages of the six channels; ir is handed on as sampled.
// Depends on awas_pkg and awas_ram. Clears the history RAM after reset.
module awas_front #(
    parameter int WINDOW = awas_pkg::DEF_WINDOW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [6*12-1:0]       i_samples,
    output logic                  o_valid,
    input  logic                  i_ready,
    output awas_pkg::t_avg        o_avg
);
    import awas_pkg::*;

    localparam int PW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int AW   = $clog2(NUM_CH * WINDOW);
    localparam int SW   = SAMPLE_W + PW + 1;
    localparam int CW   = $clog2(NUM_CH + 1);
    localparam int DEPTH = NUM_CH * WINDOW;
    // The average is sum / WINDOW, taken as a multiplication by the rounded-up
    // reciprocal scaled by 2^RK; this is exact for every sum the window can hold.
    localparam int RK   = 40;
    localparam logic [RK-1:0] AVG_RECIP =
        RK'(((64'd1 << RK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_UPD, S_OUT} t_state;

    t_state                r_state;
    logic [AW-1:0]         r_clr;
    logic [PW-1:0]         r_pos;
    logic [CW-1:0]         r_ch;
    logic [6*12-1:0]       r_smp;
    logic [SW-1:0]         r_sum [NUM_CH];
    logic [SAMPLE_W-1:0]   r_avg [NUM_CH];
    logic                  r_rd_wait;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [SAMPLE_W-1:0]   w_wdata;
    logic [SAMPLE_W-1:0]   w_old;
    logic [SAMPLE_W-1:0]   w_new;
    logic [SW-1:0]         w_sum;
    logic [SW+RK-1:0]      w_prod;
    logic [AW-1:0]         w_base;

    assign w_base  = AW'(r_ch) * AW'(WINDOW) + AW'(r_pos);
    assign w_new   = r_smp[r_ch[2:0]*12 +: 12];
    assign w_sum   = r_sum[r_ch[2:0]] - SW'(w_old) + SW'(w_new);
    assign w_prod  = (SW+RK)'(w_sum) * (SW+RK)'(AVG_RECIP);
    assign w_raddr = w_base;
    assign w_we    = (r_state == S_CLEAR) || (r_state == S_UPD && r_rd_wait);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : w_base;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : w_new;

    awas_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_hist (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_old)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_avg.avg_vout   = r_avg[0];
    assign o_avg.avg_vin    = r_avg[1];
    assign o_avg.ir         = r_smp[2*12 +: 12];
    assign o_avg.avg_isense = r_avg[3];
    assign o_avg.avg_temp   = r_avg[4];
    assign o_avg.avg_vref   = r_avg[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_pos     <= '0;
            r_ch      <= '0;
            r_rd_wait <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) r_sum[i] <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_smp   <= i_samples;
                        r_ch    <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_rd_wait <= 1'b1;
                    r_state   <= S_UPD;
                end
                S_UPD: begin
                    r_rd_wait <= 1'b0;
                    r_sum[r_ch[2:0]] <= w_sum;
                    r_avg[r_ch[2:0]] <= SAMPLE_W'(w_prod >> RK);
                    if (r_ch == CW'(NUM_CH - 1)) begin
                        r_pos   <= (r_pos == PW'(WINDOW - 1)) ? '0 : r_pos + PW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_ch    <= r_ch + CW'(1);
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/awas_fifo.sv -----
// Two-entry queue of averaged scans between the front and back parts.
// Depends on awas_pkg.
module awas_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  awas_pkg::t_avg i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output awas_pkg::t_avg o_data
);
    import awas_pkg::*;

    t_avg       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ----- rtl/awas_back.sv -----
// Back part: scales averages to millivolts, milliamps and die temperature.
// Depends on awas_pkg. Temperature uses a bit-serial divider on magnitudes, signed after.
module awas_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [11:0]    i_vref_cal,
    input  logic [11:0]    i_cal_cold,
    input  logic [11:0]    i_cal_hot,
    input  logic           i_valid,
    output logic           o_ready,
    input  awas_pkg::t_avg i_avg,
    output logic           o_valid,
    input  logic           i_ready,
    output awas_pkg::t_res o_res
);
    import awas_pkg::*;

    // Numerator magnitude at most 800*4095*4095 < 2^34; quotient width 34.
    localparam int NW = 34;
    localparam int DW = 25;

    // Scale factors as reciprocal multiplications by 2^32 that are exact over
    // the 12-bit average range: 36300/4095 = 2420/273 and 3300/1638 = 1650/819.
    localparam logic [35:0] MV_SCALE = 36'd38072604020;
    localparam logic [33:0] MA_SCALE = 34'd8652865650;

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_DIV, S_FIN, S_OUT} t_state;

    t_state             r_state;
    t_avg               r_a;
    logic [5:0]         r_bit;
    logic signed [25:0] r_p1;      // avg_temp*vref_cal - cold*avg_vref
    logic signed [12:0] r_span;
    logic [NW-1:0]      r_num;
    logic [DW-1:0]      r_den;
    logic [NW-1:0]      r_quo;
    logic [DW:0]        r_rem;
    logic               r_neg;
    logic               r_dz;
    logic [15:0]        r_vin;
    logic [15:0]        r_vout;
    logic [11:0]        r_cmag;    // |2048 - avg_isense|
    logic               r_cneg;
    logic [12:0]        r_cq;
    t_res               r_res;

    logic [DW:0]        w_trial;
    logic signed [NW+1:0] w_t;
    logic [NW+1:0]      w_mag;

    assign w_trial = {r_rem[DW-1:0], r_num[NW-1]};
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_res   = r_res;
    assign w_mag   = {2'b00, r_quo};
    assign w_t     = r_neg ? (36'sd300 - $signed(w_mag)) : (36'sd300 + $signed(w_mag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_a     <= i_avg;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p1   <= $signed(26'(r_a.avg_temp) * 26'(i_vref_cal))
                            - $signed(26'(i_cal_cold) * 26'(r_a.avg_vref));
                    r_span <= $signed({1'b0, i_cal_hot}) - $signed({1'b0, i_cal_cold});
                    r_vin  <= 16'((48'(r_a.avg_vin) * 48'(MV_SCALE)) >> 32);
                    r_vout <= 16'((48'(r_a.avg_vout) * 48'(MV_SCALE)) >> 32);
                    r_cneg <= (r_a.avg_isense > 12'd2048);
                    r_cmag <= (r_a.avg_isense > 12'd2048) ? r_a.avg_isense - 12'd2048
                                                          : 12'd2048 - r_a.avg_isense;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    logic [25:0] v_pm;
                    logic [11:0] v_sm;
                    v_pm = r_p1[25] ? 26'(-r_p1) : 26'(r_p1);
                    v_sm = r_span[12] ? 12'(-r_span) : 12'(r_span);
                    r_num <= NW'(v_pm) * NW'(800);
                    r_den <= DW'(r_a.avg_vref) * DW'(v_sm);
                    r_neg <= r_p1[25] ^ r_span[12];
                    r_dz  <= (r_a.avg_vref == '0) || (r_span == '0);
                    r_cq  <= 13'((46'(r_cmag) * 46'(MA_SCALE)) >> 32);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_bit <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_num <= {r_num[NW-2:0], 1'b0};
                    if (w_trial >= {1'b0, r_den}) begin
                        r_rem <= w_trial - {1'b0, r_den};
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                    r_bit <= r_bit + 6'd1;
                    if (r_bit == 6'(NW - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res.vin_mv     <= r_vin;
                    r_res.vout_mv    <= r_vout;
                    r_res.current_ma <= r_cneg ? 14'(-{1'b0, r_cq}) : {1'b0, r_cq};
                    r_res.ir_level   <= r_a.ir;
                    r_res.temp_valid <= !r_dz;
                    if (r_dz) r_res.temp_tenths <= '0;
                    else if (w_t < -36'sd550) r_res.temp_tenths <= 12'(-13'sd550);
                    else if (w_t > 36'sd1500) r_res.temp_tenths <= 12'd1500;
                    else r_res.temp_tenths <= 12'(w_t);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- rtl/adc_window_average_scaler.sv -----
// Top level of the ADC window average scaler: configuration registers and the
// front part, queue and back part. Depends on awas_pkg and the awas_* modules.
//
// Each transaction on the slave side carries one scan of six 12-bit channels;
// one transaction with the scaled result leaves on the master side. The front
// part walks the six channels through one history RAM (a read state and an
// update state per channel, plus accept and hand-over). The back part, which
// governs the sustained rate, takes each scan through accept, two multiply
// states, 34 steps of its bit-serial temperature divider, a finishing state and
// the output state. A two-entry queue lets each side stall on its own. After
// reset the history RAM, all 6*WINDOW entries, is cleared, during which no scan is
// accepted. Configuration writes are meant to happen only while the block is idle.
module adc_window_average_scaler #(
    parameter int WINDOW = awas_pkg::DEF_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vout[11:0], vin[23:12], ir[35:24], isense[47:36], temp[59:48], vref[71:60]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // vin_mv[15:0], vout_mv[31:16], current_ma[45:32], ir_level[57:46],
    // temp_tenths[69:58], temp_valid[70], zeros[71]
    output logic [71:0] m_axis_tdata
);
    import awas_pkg::*;

    logic [11:0] r_vref_cal;
    logic [11:0] r_cal_cold;
    logic [11:0] r_cal_hot;
    logic        w_fv;
    logic        w_fr;
    t_avg        w_fa;
    logic        w_qv;
    logic        w_qr;
    t_avg        w_qa;
    t_res        w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vref_cal <= RST_VREF_CAL;
            r_cal_cold <= RST_CAL_COLD;
            r_cal_hot  <= RST_CAL_HOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VREF_CAL: r_vref_cal <= i_cfg_data;
                REG_CAL_COLD: r_cal_cold <= i_cfg_data;
                REG_CAL_HOT:  r_cal_hot  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    awas_front #(.WINDOW(WINDOW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_samples(s_axis_tdata),
        .o_valid(w_fv), .i_ready(w_fr), .o_avg(w_fa)
    );

    awas_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fv), .o_ready(w_fr), .i_data(w_fa),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_qa)
    );

    awas_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vref_cal(r_vref_cal), .i_cal_cold(r_cal_cold), .i_cal_hot(r_cal_hot),
        .i_valid(w_qv), .o_ready(w_qr), .i_avg(w_qa),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {1'b0, w_res.temp_valid, w_res.temp_tenths, w_res.ir_level,
                           w_res.current_ma, w_res.vout_mv, w_res.vin_mv};
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the ADC window average scaler: random scans on the slave side,
// results predicted and compared on the master side. Depends on awas_pkg and the RTL in rtl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import awas_pkg::*;

    localparam int WIN = DEF_WINDOW;
    localparam int CLEAR_CYCLES = 6 * WIN + 50;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [11:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    adc_window_average_scaler dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scaler model state: the sample windows, their running sums and the calibration.
    logic [11:0] hist [NUM_CH][WIN];
    int unsigned chan_sum [NUM_CH];
    int unsigned wr_pos;
    logic [11:0] cal_vref, cal_cold, cal_hot;

    logic [71:0] scan_queue [$];    // scans waiting to be driven
    logic [71:0] result_queue [$];  // predicted result words, oldest first
    int errors = 0;
    bit sender_pause = 0;
    int hold_off = 0;               // long receiver stall requested by the stimulus

    // Works out the result word for one accepted scan and advances the windows.
    function automatic logic [71:0] scale_scan(logic [71:0] scan);
        logic [11:0] s;
        int unsigned avg [NUM_CH];
        longint cur, span, den, num, temp;
        logic [31:0] vin, vout;
        logic valid;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            s = scan[ch*12 +: 12];
            chan_sum[ch] = chan_sum[ch] - hist[ch][wr_pos] + s;
            hist[ch][wr_pos] = s;
            avg[ch] = chan_sum[ch] / WIN;
        end
        wr_pos = (wr_pos + 1) % WIN;
        // Channel order in tdata: vout, vin, ir, isense, temp, vref.
        vout = 32'((longint'(avg[0]) * 36300) / 4095);
        vin  = 32'((longint'(avg[1]) * 36300) / 4095);
        cur  = ((2048 - longint'(avg[3])) * 3300) / 1638;
        span = longint'(cal_hot) - longint'(cal_cold);
        den  = longint'(avg[5]) * span;
        temp = 0;
        valid = 1'b0;
        if (den != 0) begin
            num = 800 * (longint'(avg[4]) * longint'(cal_vref)
                         - longint'(cal_cold) * longint'(avg[5]));
            temp = 300 + num / den;
            if (temp < -550) temp = -550;
            if (temp > 1500) temp = 1500;
            valid = 1'b1;
        end
        return {1'b0, valid, temp[11:0], scan[35:24], cur[13:0], vout[15:0], vin[15:0]};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 40);
        return $urandom_range(41, 150);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Driver: offers the next queued scan, with random gaps between transactions.
    int gap = 0;
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            result_queue.push_back(scale_scan(s_axis_tdata));
            void'(scan_queue.pop_front());
            gap = pick_gap();
        end
        if (gap > 0) begin
            gap--;
            s_axis_tvalid <= 1'b0;
        end else if (!sender_pause && i_rst_n && scan_queue.size() > 0) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= scan_queue[0];
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor: compares each result transaction with the oldest prediction.
    int stall = 0;
    always @(posedge i_clk) begin
        logic [71:0] want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = result_queue.pop_front();
                check_field("vin_mv", want[15:0], m_axis_tdata[15:0]);
                check_field("vout_mv", want[31:16], m_axis_tdata[31:16]);
                check_field("current_ma", want[45:32], m_axis_tdata[45:32]);
                check_field("ir_level", want[57:46], m_axis_tdata[57:46]);
                check_field("temp_tenths", want[69:58], m_axis_tdata[69:58]);
                check_field("temp_valid", want[71:70], m_axis_tdata[71:70]);
            end
            stall = pick_gap();
        end
        if (hold_off > 0) begin
            hold_off--;
            m_axis_tready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_VREF_CAL) cal_vref = val;
        else if (idx == REG_CAL_COLD) cal_cold = val;
        else if (idx == REG_CAL_HOT) cal_hot = val;
    endtask

    task automatic wait_idle();
        while (scan_queue.size() > 0 || result_queue.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [71:0] rand_scan();
        logic [71:0] v;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            case ($urandom_range(0, 5))
                0: v[ch*12 +: 12] = 12'd0;
                1: v[ch*12 +: 12] = 12'hFFF;
                default: v[ch*12 +: 12] = 12'($urandom_range(0, 4095));
            endcase
        end
        return v;
    endfunction

    // Pushes a run of scans; each run mostly holds channels near a level so that
    // the averages settle and span the scale.
    task automatic push_run(int count);
        logic [11:0] level [NUM_CH];
        logic [71:0] v;
        for (int ch = 0; ch < NUM_CH; ch++) level[ch] = 12'($urandom_range(0, 4095));
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                v = rand_scan();
            end else begin
                for (int ch = 0; ch < NUM_CH; ch++)
                    v[ch*12 +: 12] = level[ch] ^ 12'($urandom_range(0, 15));
            end
            scan_queue.push_back(v);
        end
    endtask

    initial begin
        cal_vref = RST_VREF_CAL;
        cal_cold = RST_CAL_COLD;
        cal_hot  = RST_CAL_HOT;
        wr_pos = 0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            chan_sum[ch] = 0;
            for (int k = 0; k < WIN; k++) hist[ch][k] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (CLEAR_CYCLES) @(posedge i_clk);

        // Directed part: extremes of every channel; the reference average stays
        // zero at first, which exercises the zero-divisor case.
        scan_queue.push_back('0);
        scan_queue.push_back({6{12'hFFF}});
        scan_queue.push_back({12'h000, 12'hFFF, 12'h800, 12'hAAA, 12'h555, 12'hFFF});
        for (int k = 0; k < 10; k++) scan_queue.push_back({6{12'hFFF}});
        scan_queue.push_back({12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000});
        wait_idle();
        // Equal calibration points: zero span.
        write_reg(REG_CAL_HOT, cal_cold);
        push_run(5);
        wait_idle();
        // Inverted span and extreme calibration values; an unused index is ignored.
        write_reg(REG_CAL_COLD, 12'hFFF);
        write_reg(REG_CAL_HOT, 12'h000);
        write_reg(REG_VREF_CAL, 12'hFFF);
        write_reg(2'd3, 12'h123);
        push_run(5);

        // Random part in phases of differing calibration.
        for (int ph = 0; ph < 14; ph++) begin
            wait_idle();
            case (ph % 4)
                0: begin
                    write_reg(REG_VREF_CAL, RST_VREF_CAL);
                    write_reg(REG_CAL_COLD, RST_CAL_COLD);
                    write_reg(REG_CAL_HOT, RST_CAL_HOT);
                end
                1: begin
                    write_reg(REG_VREF_CAL, 12'h000);
                    write_reg(REG_CAL_COLD, 12'h000);
                    write_reg(REG_CAL_HOT, 12'h001);
                end
                default: begin
                    write_reg(REG_VREF_CAL, 12'($urandom_range(0, 4095)));
                    write_reg(REG_CAL_COLD, 12'($urandom_range(0, 4095)));
                    write_reg(REG_CAL_HOT, 12'($urandom_range(0, 4095)));
                end
            endcase
            if (ph == 3) hold_off = 3000;   // receiver stalls, input side backs up
            for (int r = 0; r < 4; r++) push_run(30);
            if (ph == 6) begin
                // Sender waits for every outstanding result before going on.
                while (scan_queue.size() > 0) @(posedge i_clk);
                sender_pause = 1;
                while (result_queue.size() > 0) @(posedge i_clk);
                sender_pause = 0;
                push_run(20);
            end
        end
        wait_idle();
        if (errors == 0 && result_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
